// ===== design/smscan_pkg.sv =====
// Shared types and constants for the substring match scanner.
package smscan_pkg;

  localparam int unsigned MaxPattern = 8;
  localparam longint unsigned MaxText = 64'd65536;
  localparam longint unsigned PosLimit = 64'd65536;
  localparam longint unsigned PosRange = (MaxText < PosLimit) ? MaxText : PosLimit;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 4;
  localparam int unsigned SlotW = $clog2(MaxPattern);
  localparam int unsigned PatW = ByteW * MaxPattern;
  localparam int unsigned PosW = 17;
  localparam int unsigned IdxW = 16;
  localparam int unsigned CntW = 17;
  localparam int unsigned CfgDataW = 64;

  localparam logic [PosW-1:0] PosRangeV = PosW'(PosRange);
  localparam logic [PosW:0] PosTopV = (PosW + 1)'(PosRange - 64'd1);
  localparam logic [CntW-1:0] CountLimitV = CntW'(65536);
  localparam logic [LenW-1:0] MaxPatternV = LenW'(MaxPattern);

  typedef enum logic [0:0] {
    CfgPattern = 1'b0,
    CfgLength  = 1'b1
  } cfg_reg_e;

  // One accepted text request as seen by the tracker.
  typedef struct packed {
    logic accept;
    logic last;
    logic win_ok;
  } step_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] last_index;
    logic [CntW-1:0] match_count;
    logic            overflow;
  } res_t;

  // Saturate a match start to the top of the position range.
  function automatic logic [IdxW-1:0] clip_start(input logic [PosW:0] s);
    logic [PosW:0] v;
    v = (s > PosTopV) ? PosTopV : s;
    return v[IdxW-1:0];
  endfunction

endpackage

// ===== design/smscan_text_if.sv =====
// Text byte channel: one request per text byte.
interface smscan_text_if;
  import smscan_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

// ===== design/smscan_result_if.sv =====
// Result channel: one request per finished text.
interface smscan_result_if;
  import smscan_pkg::*;
  logic            valid;
  logic            ready;
  logic            found;
  logic [IdxW-1:0] first_index;
  logic [IdxW-1:0] last_index;
  logic [CntW-1:0] match_count;
  logic            overflow;

  modport source (output valid, output found, output first_index, output last_index,
                  output match_count, output overflow, input ready);
  modport sink (input valid, input found, input first_index, input last_index,
                input match_count, input overflow, output ready);
endinterface

// ===== design/smscan_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface smscan_cfg_if;
  import smscan_pkg::*;
  logic                valid;
  logic                ready;
  cfg_reg_e            index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/substring_match_scanner.sv =====
// Substring match scanner top level: config registers, window cells, tracker, result register.
//
// Usage: write the pattern bytes (index 0, byte zero in bits 7..0) and the pattern
// length (index 1, 0 = empty pattern, above 8 treated as 8) on cfg_i while no text
// is in flight. Stream the text on text_i, one byte per request, with final_byte
// set on the last byte. Each byte shifts through a row of eight cells that compare
// it against the pattern; the tracker records the first and last match start and
// a count of non-overlapping matches.
// Throughput: one text byte per cycle while text_i is ready; the window compare
// and tracker update both finish in the cycle the byte is accepted.
// The result appears on result_o in the cycle after the final byte is taken.
// The result register holds it until result_o.ready; text_i stays ready while the
// result register is empty or being drained, so a stalled receiver only blocks a
// new text byte when the held result has not been taken yet.
// Reset: clears the pattern registers to zero, the window and all scan state, and
// drops any pending result. cfg_i is always ready.
module substring_match_scanner
  import smscan_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  smscan_cfg_if.sink      cfg_i,
  smscan_text_if.sink     text_i,
  smscan_result_if.source result_o
);

  logic [MaxPattern-1:0][ByteW-1:0] pattern_q;
  logic [LenW-1:0]                  plen_q;
  logic [LenW-1:0]                  len_eff;

  logic                             text_acc;
  logic                             res_valid_q;
  res_t                             res_q, res_next;
  step_t                            step;

  logic [MaxPattern-1:0][ByteW-1:0] cell_in, cell_out, cell_want;
  logic [MaxPattern-1:0]            cell_active, cell_match;
  logic [LenW-1:0]                  sel [MaxPattern];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgPattern: pattern_q <= cfg_i.data;
        CfgLength:  plen_q    <= cfg_i.data[LenW-1:0];
        default:    ;
      endcase
    end
  end

  assign len_eff = (plen_q > MaxPatternV) ? MaxPatternV : plen_q;

  // Cell k compares the byte k places back; it checks pattern byte len-1-k.
  always_comb begin
    for (int k = 0; k < MaxPattern; k++) begin
      sel[k]         = len_eff - LenW'(k) - LenW'(1);
      cell_active[k] = LenW'(k) < len_eff;
      cell_want[k]   = pattern_q[sel[k][SlotW-1:0]];
      cell_in[k]     = (k == 0) ? text_i.text_byte : cell_out[(k == 0) ? 0 : k - 1];
    end
  end

  assign text_acc = text_i.valid && text_i.ready;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    smscan_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (text_acc),
      .clr_i    (text_acc && text_i.final_byte),
      .byte_i   (cell_in[k]),
      .want_i   (cell_want[k]),
      .active_i (cell_active[k]),
      .byte_o   (cell_out[k]),
      .match_o  (cell_match[k])
    );
  end

  assign step.accept = text_acc;
  assign step.last   = text_i.final_byte;
  assign step.win_ok = &cell_match;

  smscan_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .len_i  (len_eff),
    .res_o  (res_next)
  );

  assign text_i.ready = !res_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (text_acc && text_i.final_byte) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_acc && text_i.final_byte) begin
      res_q <= res_next;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.found       = res_q.found;
  assign result_o.first_index = res_q.first_index;
  assign result_o.last_index  = res_q.last_index;
  assign result_o.match_count = res_q.match_count;
  assign result_o.overflow    = res_q.overflow;

endmodule

// ===== design/smscan_cell.sv =====
// One window cell: holds a text byte, passes it on and compares the incoming byte.
module smscan_cell
  import smscan_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             clr_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] want_i,
  input  logic             active_i,
  output logic [ByteW-1:0] byte_o,
  output logic             match_o
);

  logic [ByteW-1:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (clr_i) begin
      byte_q <= '0;
    end else if (en_i) begin
      byte_q <= byte_i;
    end
  end

  // Slots past the pattern length always agree.
  assign match_o = !active_i || (byte_i == want_i);
  assign byte_o  = byte_q;

endmodule

// ===== design/smscan_track.sv =====
// Scan tracker: position, first and last match start, match count and overflow.
module smscan_track
  import smscan_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  step_t           step_i,
  input  logic [LenW-1:0] len_i,
  output res_t            res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            seen_q, seen_d;
  logic [IdxW-1:0] first_q, first_d;
  logic [IdxW-1:0] last_q, last_d;
  logic [CntW-1:0] tally_q, tally_d;
  logic [LenW-1:0] skip_q, skip_d;
  logic            ovf_q, ovf_d;

  logic [PosW:0]   p1, s_a, s_b;
  logic            empty, hit, rec_a, rec_b, cnt_a, cnt_b;
  logic [CntW-1:0] t_mid;

  always_comb begin
    empty = (len_i == '0);
    p1    = {1'b0, pos_q} + (PosW + 1)'(1);
    hit   = !empty && step_i.win_ok && (p1 >= {{(PosW + 1 - LenW){1'b0}}, len_i});
    s_a   = empty ? {1'b0, pos_q} : p1 - {{(PosW + 1 - LenW){1'b0}}, len_i};
    s_b   = p1;
    rec_a = empty || hit;
    rec_b = empty && step_i.last;
    cnt_a = empty || (hit && (skip_q == '0));
    cnt_b = rec_b;

    pos_d   = pos_q;
    ovf_d   = ovf_q;
    seen_d  = seen_q;
    first_d = first_q;
    last_d  = last_q;
    skip_d  = skip_q;

    if (pos_q >= PosRangeV) begin
      ovf_d = 1'b1;
    end else begin
      pos_d = p1[PosW-1:0];
    end

    if (rec_a) begin
      if (s_a > PosTopV) ovf_d = 1'b1;
      if (!seen_d) first_d = clip_start(s_a);
      seen_d = 1'b1;
      last_d = clip_start(s_a);
    end
    if (rec_b) begin
      if (s_b > PosTopV) ovf_d = 1'b1;
      last_d = clip_start(s_b);
    end

    // Count with saturation, up to two matches in one request.
    t_mid = tally_q;
    if (cnt_a) begin
      if (tally_q >= CountLimitV) ovf_d = 1'b1;
      else t_mid = tally_q + CntW'(1);
    end
    tally_d = t_mid;
    if (cnt_b) begin
      if (t_mid >= CountLimitV) ovf_d = 1'b1;
      else tally_d = t_mid + CntW'(1);
    end

    // Suppress counting for the rest of a counted match.
    if (!empty) begin
      if (hit && (skip_q == '0)) begin
        skip_d = len_i - LenW'(1);
      end else if (skip_q != '0) begin
        skip_d = skip_q - LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      seen_q  <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
      tally_q <= '0;
      skip_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i.accept) begin
      if (step_i.last) begin
        pos_q   <= '0;
        seen_q  <= 1'b0;
        first_q <= '0;
        last_q  <= '0;
        tally_q <= '0;
        skip_q  <= '0;
        ovf_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        seen_q  <= seen_d;
        first_q <= first_d;
        last_q  <= last_d;
        tally_q <= tally_d;
        skip_q  <= skip_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_comb begin
    res_o.found       = seen_d;
    res_o.first_index = first_d;
    res_o.last_index  = last_d;
    res_o.match_count = tally_d;
    res_o.overflow    = ovf_d;
  end

endmodule

// ===== design/smscan_checker.sv =====
// Port-level checks for the substring match scanner, bound to the top level.
module smscan_checker
  import smscan_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_final,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_found,
  input logic [IdxW-1:0] out_first,
  input logic [IdxW-1:0] out_last,
  input logic [CntW-1:0] out_count
);

  // A held result keeps its payload until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_last)
      && $stable(out_count) && $stable(out_found))
    else $error("result changed while stalled");

  // The final byte produces a result on the next cycle.
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_final |=> out_valid)
    else $error("no result after final byte");

  // Other bytes produce none.
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !in_final && !(out_valid && !out_ready) |=> !out_valid)
    else $error("result without final byte");

  // No match means all-zero indexes and count; a match means a nonzero count.
  a_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_found ? (out_count != '0 && out_first <= out_last)
                             : (out_first == '0 && out_last == '0 && out_count == '0)))
    else $error("inconsistent match result");

endmodule

bind substring_match_scanner smscan_checker u_smscan_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (text_i.valid),
  .in_ready  (text_i.ready),
  .in_final  (text_i.final_byte),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_found (result_o.found),
  .out_first (result_o.first_index),
  .out_last  (result_o.last_index),
  .out_count (result_o.match_count)
);
